@@ hw/rtl/sap_pkg.sv @@
// Shared types, constants and fixed-point helpers for the stereo phaser.
// No dependencies; every other file uses this package.
package sap_pkg;

    localparam int PHASE_W  = 24;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 17;
    localparam int PROD_W   = 37;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h40_0000;
    localparam logic [16:0]        UNITY_Q16    = 17'd65536;

    localparam logic [2:0] REG_PHASE_STEP = 3'd0;
    localparam logic [2:0] REG_DEPTH      = 3'd1;
    localparam logic [2:0] REG_WET_MIX    = 3'd2;
    localparam logic [2:0] REG_FEEDBACK   = 3'd3;
    localparam logic [2:0] REG_BYPASS     = 3'd4;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // settings each lane needs, already clamped to range
    typedef struct packed {
        logic [16:0] depth;
        logic [16:0] mix;
        t_sample     fb;
    } t_lane_cfg;

    typedef struct packed {
        logic               start;
        logic [PHASE_W-1:0] phase;
        t_sample            dry;
    } t_lane_req;

    typedef struct packed {
        logic    done;
        t_sample wet_out;
    } t_lane_rsp;

    // floor(p / 2^sh + 1/2)
    function automatic logic signed [PROD_W:0] round_shift(
        input logic signed [PROD_W-1:0] p,
        input int unsigned              sh
    );
        logic signed [PROD_W:0] t;
        t = {p[PROD_W-1], p} + ((PROD_W+1)'(1) <<< (sh - 1));
        return t >>> sh;
    endfunction

    function automatic t_sample sat16(input logic signed [PROD_W+1:0] v);
        if (v > 32767)
            return 16'sh7fff;
        else if (v < -32768)
            return 16'sh8000;
        else
            return v[SAMPLE_W-1:0];
    endfunction

    // restoring shift/subtract quotient, used only while building tables
    function automatic longint unsigned div_u64(
        input longint unsigned a,
        input longint unsigned b
    );
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sine and cosine in Q30 of x in Q30, 0 <= x <= pi/2, packed as {sin, cos}
    function automatic logic [127:0] sincos_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint          ss;
        longint          cc;
        x2 = (x * x) >> 30;
        ts = x;
        tc = Q30_ONE;
        ss = longint'(x);
        cc = longint'(Q30_ONE);
        for (int n = 1; n <= 8; n++) begin
            ts = div_u64((ts * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
            tc = div_u64((tc * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1) begin
                ss = ss - longint'(ts);
                cc = cc - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cc = cc + longint'(tc);
            end
        end
        return {ss, cc};
    endfunction

endpackage

@@ hw/rtl/sap_in_if.sv @@
// Input channel: one stereo sample pair per transaction.
// Depends on sap_pkg.
interface sap_in_if;
    logic                  valid;
    logic                  ready;
    sap_pkg::t_sample      left_in;
    sap_pkg::t_sample      right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

@@ hw/rtl/sap_out_if.sv @@
// Output channel: one processed stereo pair per transaction.
// Depends on sap_pkg.
interface sap_out_if;
    logic                  valid;
    logic                  ready;
    sap_pkg::t_sample      left_out;
    sap_pkg::t_sample      right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ hw/rtl/sap_lane.sv @@
// One channel of the phaser: LFO/coefficient lookup, feedback, all-pass chain
// and dry/wet mix, sequenced over one shared multiplier. Depends on sap_pkg.
module sap_lane #(
    parameter int STAGES      = 4,
    parameter int SAMPLE_RATE = 48000,
    parameter int COS_DEPTH   = 256,
    parameter int COEF_DEPTH  = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sap_pkg::t_lane_cfg  i_cfg,
    input  sap_pkg::t_lane_req  i_req,
    output sap_pkg::t_lane_rsp  o_rsp
);
    import sap_pkg::*;

    localparam int LI_W  = $clog2(COS_DEPTH);
    localparam int CI_W  = $clog2(COEF_DEPTH);
    localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    typedef logic [COS_DEPTH-1:0][16:0]         t_lfo_rom;
    typedef logic [COEF_DEPTH-1:0][17:0]        t_coef_rom;

    function automatic t_lfo_rom build_lfo();
        t_lfo_rom        tab;
        longint unsigned th;
        logic            neg;
        logic [127:0]    sc;
        longint          c;
        longint          r;
        for (int k = 0; k < COS_DEPTH; k++) begin
            th  = (2 * PI_Q30 * longint'(k) + COS_DEPTH / 2) / COS_DEPTH;
            neg = 1'b0;
            if (th > PI_Q30)
                th = 2 * PI_Q30 - th;
            if (th > HALF_PI_Q30) begin
                th  = PI_Q30 - th;
                neg = 1'b1;
            end
            sc = sincos_q30(th);
            c  = longint'(sc[63:0]);
            if (neg)
                c = -c;
            r = longint'(Q30_ONE) - c + 16384;
            if (r < 0)
                r = 0;
            r = r >>> 15;
            if (r > 65536)
                r = 65536;
            tab[k] = 17'(r);
        end
        return tab;
    endfunction

    function automatic t_coef_rom build_coef();
        t_coef_rom       tab;
        longint unsigned span;
        longint unsigned num;
        longint unsigned den;
        longint unsigned x;
        longint unsigned mag;
        longint unsigned sum;
        logic [127:0]    sc;
        longint          s;
        longint          c;
        longint          d;
        longint          q;
        span = longint'(COEF_DEPTH - 1);
        den  = span * longint'(SAMPLE_RATE);
        for (int k = 0; k < COEF_DEPTH; k++) begin
            num = PI_Q30 * (200 * span + 1600 * longint'(k));
            x   = div_u64(num + den / 2, den);
            if (x > HALF_PI_Q30)
                x = HALF_PI_Q30;
            sc  = sincos_q30(x);
            s   = longint'(sc[127:64]);
            c   = longint'(sc[63:0]);
            d   = s - c;
            sum = longint'(s + c);
            if (sum == 0)
                sum = 1;
            mag = (d < 0) ? longint'(-d) : longint'(d);
            q   = longint'(div_u64((mag << 17) + sum / 2, sum));
            if (d < 0)
                q = -q;
            if (q > 131071)
                q = 131071;
            if (q < -131072)
                q = -131072;
            tab[k] = 18'(q);
        end
        return tab;
    endfunction

    localparam t_lfo_rom  LFO_ROM  = build_lfo();
    localparam t_coef_rom COEF_ROM = build_coef();

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_IDX   = 9'b0_0000_0010,
        S_LFO   = 9'b0_0000_0100,
        S_SWEEP = 9'b0_0000_1000,
        S_COEF  = 9'b0_0001_0000,
        S_MUL   = 9'b0_0010_0000,
        S_ACC   = 9'b0_0100_0000,
        S_MIXM  = 9'b0_1000_0000,
        S_OUT   = 9'b1_0000_0000
    } t_state;

    t_state                    r_state;
    logic [PHASE_W-1:0]        r_phase;
    t_sample                   r_dry;
    logic [LI_W-1:0]           r_li;
    logic [CI_W-1:0]           r_ci;
    logic signed [17:0]        r_g;
    t_sample                   r_v;
    logic [IDX_W-1:0]          r_idx;
    logic signed [PROD_W-1:0]  r_prod;
    t_sample                   r_xs [STAGES];
    t_sample                   r_ys [STAGES];
    t_sample                   r_last_wet;
    t_sample                   r_out;

    logic signed [18:0]        w_ma;
    logic signed [17:0]        w_mb;
    logic [PHASE_W+LI_W-1:0]   w_li_prod;
    logic [16:0]               w_s;
    logic [CI_W+17:0]          w_ci_sum;
    logic [CI_W+1:0]           w_ci_full;
    t_sample                   w_y;

    assign w_li_prod = (PHASE_W+LI_W)'(r_phase) * (PHASE_W+LI_W)'(COS_DEPTH);
    assign w_s       = 17'((r_prod + PROD_W'(32768)) >>> 16);
    assign w_ci_sum  = (CI_W+18)'(w_s) * (CI_W+18)'(COEF_DEPTH - 1) + (CI_W+18)'(32768);
    assign w_ci_full = w_ci_sum[CI_W+17:16];
    assign w_y = sat16((PROD_W+2)'(r_xs[r_idx]) + (PROD_W+2)'(round_shift(r_prod, 17)));

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_LFO: begin
                w_ma = {2'b00, i_cfg.depth};
                w_mb = {1'b0, LFO_ROM[r_li]};
            end
            S_SWEEP: begin
                w_ma = 19'(r_last_wet);
                w_mb = 18'(i_cfg.fb);
            end
            S_MUL: begin
                w_ma = 19'(r_g);
                w_mb = 18'(r_v) - 18'(r_ys[r_idx]);
            end
            S_MIXM: begin
                w_ma = {2'b00, i_cfg.mix};
                w_mb = 18'(r_v) - 18'(r_dry);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_last_wet <= '0;
            r_idx      <= '0;
            for (int i = 0; i < STAGES; i++) begin
                r_xs[i] <= '0;
                r_ys[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= i_req.phase;
                        r_dry   <= i_req.dry;
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_li    <= w_li_prod[PHASE_W +: LI_W];
                    r_state <= S_LFO;
                end
                S_LFO: begin
                    r_prod  <= PROD_W'(w_ma * w_mb);
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (w_ci_full >= (CI_W+2)'(COEF_DEPTH - 1))
                        r_ci <= CI_W'(COEF_DEPTH - 1);
                    else
                        r_ci <= w_ci_full[CI_W-1:0];
                    r_prod  <= PROD_W'(w_ma * w_mb);
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    r_g     <= COEF_ROM[r_ci];
                    r_v     <= sat16((PROD_W+2)'(r_dry) + (PROD_W+2)'(round_shift(r_prod, 15)));
                    r_idx   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(w_ma * w_mb);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_xs[r_idx] <= r_v;
                    r_ys[r_idx] <= w_y;
                    r_v         <= w_y;
                    if (r_idx == IDX_W'(STAGES - 1)) begin
                        r_state <= S_MIXM;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MIXM: begin
                    r_prod     <= PROD_W'(w_ma * w_mb);
                    r_last_wet <= r_v;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    r_out   <= sat16((PROD_W+2)'(r_dry) + (PROD_W+2)'(round_shift(r_prod, 16)));
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // done rises on the same edge that loads the mix result into r_out
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_done <= 1'b0;
        else
            r_done <= (r_state == S_OUT);
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.wet_out = r_out;

endmodule

@@ hw/rtl/stereo_allpass_phaser.sv @@
// Stereo phaser top level: config registers, LFO phase accumulator, two
// channel lanes and the output register. Depends on sap_pkg, sap_in_if,
// sap_out_if and sap_lane.
//
// Usage: stereo pairs enter on i_in (valid/ready) and processed pairs leave
// on o_out (valid/ready). Settings are written through i_cfg_we/i_cfg_idx/
// i_cfg_data only while the block is idle; this binds the user, since the
// block itself does not enforce it. Each pair is handled by two lanes at
// once, one per channel; each lane sequences its work over one shared
// multiplier, and each result passes into the result register and then
// into the output register. A new pair is accepted once the previous
// result has moved to the output register, so pairs never overlap.
// Bypass pairs skip the lanes and go into the result and output registers.
// Reset loads the default settings and clears phase, all-pass state and
// feedback memory; coefficient tables are constants, so no warm-up is needed.
// If the receiver stalls, one result waits in the output register and one
// more in the result holding register; input is then held off.
module stereo_allpass_phaser #(
    parameter int STAGES      = 4,
    parameter int SAMPLE_RATE = 48000,
    parameter int COS_DEPTH   = 256,
    parameter int COEF_DEPTH  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sap_in_if.sink                     i_in,
    sap_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [sap_pkg::CFG_W-1:0]  i_cfg_data
);
    import sap_pkg::*;

    logic [11:0]        r_step;
    logic [16:0]        r_depth;
    logic [16:0]        r_mix;
    t_sample            r_fb;
    logic               r_bypass;
    logic [PHASE_W-1:0] r_phase;
    logic               r_busy;
    logic               r_have;
    logic               r_ov;
    t_sample            r_rl;
    t_sample            r_rr;
    t_sample            r_ol;
    t_sample            r_or;

    logic               w_acc;
    logic               w_move;
    logic [PHASE_W-1:0] n_phase;
    t_lane_cfg          w_cfg;
    t_lane_req          w_req_l;
    t_lane_req          w_req_r;
    t_lane_rsp          w_rsp_l;
    t_lane_rsp          w_rsp_r;

    assign i_in.ready = !r_busy;
    assign w_acc      = i_in.valid && !r_busy;
    assign w_move     = r_have && (!r_ov || o_out.ready);
    assign n_phase    = r_phase + PHASE_W'(r_step);

    assign w_cfg.depth = (r_depth > UNITY_Q16) ? UNITY_Q16 : r_depth;
    assign w_cfg.mix   = (r_mix > UNITY_Q16) ? UNITY_Q16 : r_mix;
    assign w_cfg.fb    = r_fb;

    assign w_req_l.start = w_acc && !r_bypass;
    assign w_req_l.phase = n_phase;
    assign w_req_l.dry   = i_in.left_in;
    assign w_req_r.start = w_acc && !r_bypass;
    assign w_req_r.phase = n_phase + QUARTER_TURN;
    assign w_req_r.dry   = i_in.right_in;

    sap_lane #(
        .STAGES(STAGES), .SAMPLE_RATE(SAMPLE_RATE),
        .COS_DEPTH(COS_DEPTH), .COEF_DEPTH(COEF_DEPTH)
    ) u_lane_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .i_req(w_req_l), .o_rsp(w_rsp_l)
    );

    sap_lane #(
        .STAGES(STAGES), .SAMPLE_RATE(SAMPLE_RATE),
        .COS_DEPTH(COS_DEPTH), .COEF_DEPTH(COEF_DEPTH)
    ) u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .i_req(w_req_r), .o_rsp(w_rsp_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 12'd105;
            r_depth  <= 17'd39322;
            r_mix    <= 17'd32768;
            r_fb     <= '0;
            r_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PHASE_STEP: r_step   <= i_cfg_data[11:0];
                REG_DEPTH:      r_depth  <= i_cfg_data;
                REG_WET_MIX:    r_mix    <= i_cfg_data;
                REG_FEEDBACK:   r_fb     <= i_cfg_data[15:0];
                REG_BYPASS:     r_bypass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_busy  <= 1'b0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
                if (r_bypass) begin
                    r_have <= 1'b1;
                    r_rl   <= i_in.left_in;
                    r_rr   <= i_in.right_in;
                end else begin
                    r_phase <= n_phase;
                end
            end
            if (w_rsp_l.done) begin
                r_have <= 1'b1;
                r_rl   <= w_rsp_l.wet_out;
                r_rr   <= w_rsp_r.wet_out;
            end
            if (w_move) begin
                r_have <= 1'b0;
                r_busy <= 1'b0;
                r_ov   <= 1'b1;
                r_ol   <= r_rl;
                r_or   <= r_rr;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

`ifndef NO_ASSERTIONS
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_l.done == w_rsp_r.done)
        else $error("lanes finished out of step");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_l.done |-> (r_busy && !r_have))
        else $error("lane result with no pending transaction");

    a_have_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> r_busy)
        else $error("held result outside a transaction");

    a_bypass_freezes_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_bypass) |=> $stable(r_phase))
        else $error("phase moved during bypass");
`endif

endmodule
